FILE: rtl/core/gdr_pkg.sv
// Shared types and constants for the directed graph reachability core.
package gdr_pkg;

  localparam int NODES_DEF = 256;
  localparam int NODE_W = 8;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_LOAD,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic run;
  } srch_ctl_t;

  typedef struct packed {
    logic pick;
    logic quiet;
  } srch_stat_t;

  typedef struct packed {
    logic wr;
    logic clr;
  } mem_ctl_t;

endpackage

FILE: rtl/core/gdr_adj_mem.sv
// Adjacency row memory with per-row valid bits and a registered read.
module gdr_adj_mem #(
  parameter int NODES = gdr_pkg::NODES_DEF,
  localparam int AW = $clog2(NODES)
) (
  input  logic              clk,
  input  logic              rst,
  input  gdr_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]     rd_addr,
  input  logic [AW-1:0]     wr_addr,
  input  logic [NODES-1:0]  wr_data,
  output logic [NODES-1:0]  rd_data
);
  import gdr_pkg::*;

  logic [NODES-1:0] mem [NODES];
  logic [NODES-1:0] row_valid;
  logic [NODES-1:0] rd_raw;
  logic             rd_valid;

  // A row that was never written since reset or the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (ctl.clr) begin
      row_valid <= '0;
    end else if (ctl.wr) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_raw   <= mem[rd_addr];
    rd_valid <= row_valid[rd_addr];
  end

  assign rd_data = rd_valid ? rd_raw : '0;

endmodule

FILE: rtl/core/gdr_search.sv
// Reachability search engine: frontier and visited sets, at most one row expansion per cycle.
module gdr_search #(
  parameter int NODES = gdr_pkg::NODES_DEF,
  localparam int AW = $clog2(NODES)
) (
  input  logic                clk,
  input  logic                rst,
  input  gdr_pkg::srch_ctl_t  ctl,
  input  logic [NODES-1:0]    rd_data,
  output gdr_pkg::srch_stat_t stat,
  output logic [AW-1:0]       pick_idx,
  output logic [NODES-1:0]    frontier
);
  import gdr_pkg::*;

  logic [NODES-1:0] visited;
  logic [NODES-1:0] cand;
  logic             pend;

  // Reached but not yet expanded nodes; the lowest one is expanded next.
  assign cand = frontier & ~visited;

  always_comb begin
    pick_idx = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick_idx = AW'(i);
      end
    end
  end

  assign stat.pick  = ctl.run && (cand != '0);
  assign stat.quiet = (cand == '0) && !pend;

  // The row read issued with a pick comes back in the next cycle, while pend is set.
  always_ff @(posedge clk) begin
    if (rst) begin
      frontier <= '0;
      visited  <= '0;
      pend     <= 1'b0;
    end else if (ctl.load) begin
      frontier <= rd_data;
      visited  <= '0;
      pend     <= 1'b0;
    end else if (ctl.run) begin
      if (pend) begin
        frontier <= frontier | rd_data;
      end
      if (stat.pick) begin
        visited[pick_idx] <= 1'b1;
      end
      pend <= stat.pick;
    end
  end

  ap_pick_marks: assert property (@(posedge clk) disable iff (rst)
    stat.pick |=> visited[$past(pick_idx)])
    else $error("expanded node was not marked visited");

  ap_quiet_holds: assert property (@(posedge clk) disable iff (rst)
    (ctl.run && stat.quiet) |=> stat.quiet)
    else $error("search woke up after it went quiet");

  ap_load_clears: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> (!pend && visited == '0))
    else $error("search load left stale visited state");

endmodule

FILE: rtl/core/directed_graph_reachability_core.sv
// Top level of the directed graph reachability core.
//
// One input channel (in_valid/in_ready) carries transactions with mode, source_node and
// target_node. Mode clear empties the graph in the accept cycle. Mode add sets the edge
// from source to target with a read-modify-write of the source row; the write happens in
// the EDGE state, after which the next transaction can be taken. Mode query searches from
// the source row and produces one transaction on the output channel (out_valid/out_ready)
// carrying path_exists. Mode three and add transactions naming nodes at or above NODES do
// nothing. The search expands at most one reached node per cycle, bounded by the single
// read port of the adjacency memory, and when no other node waits it idles until the row
// just read comes back. Queries naming out-of-range nodes skip the search and answer 0.
// One transaction is handled at a time.
// The result sits in an output register, so a new transaction is accepted while an
// earlier result waits; a query that finishes while the receiver still stalls holds its
// answer until the output register frees up.
// Synchronous reset empties the graph (row valid bits cleared at once, no clearing
// pass) and drops any pending result.
module directed_graph_reachability_core #(
  parameter int NODES = gdr_pkg::NODES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                mode,
  input  logic [gdr_pkg::NODE_W-1:0] source_node,
  input  logic [gdr_pkg::NODE_W-1:0] target_node,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      path_exists
);
  import gdr_pkg::*;

  localparam int AW = $clog2(NODES);
  localparam logic [NODE_W:0] NODES_LIM = (NODE_W + 1)'(NODES);

  state_t           state;
  state_t           state_next;
  mem_ctl_t         mem_ctl;
  srch_ctl_t        sctl;
  srch_stat_t       stat;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    pick_idx;
  logic [NODES-1:0] rd_data;
  logic [NODES-1:0] wr_data;
  logic [NODES-1:0] frontier;
  logic [AW-1:0]    srow;
  logic [AW-1:0]    tgt;
  logic             q_ok;
  logic             src_ok;
  logic             dst_ok;
  logic             accept;
  logic             out_load;

  assign src_ok = {1'b0, source_node} < NODES_LIM;
  assign dst_ok = {1'b0, target_node} < NODES_LIM;
  assign accept = in_valid && in_ready;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (mode)
            MODE_ADD: begin
              if (src_ok && dst_ok) begin
                state_next = ST_EDGE;
              end
            end
            MODE_QUERY: begin
              state_next = (src_ok && dst_ok) ? ST_LOAD : ST_DONE;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_EDGE: state_next = ST_IDLE;
      ST_LOAD: state_next = ST_RUN;
      ST_RUN: begin
        if (stat.quiet) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output decode. While idle the memory reads the row of the offered source node, so
  // the row is ready in the cycle after the transaction is accepted.
  always_comb begin
    in_ready    = (state == ST_IDLE);
    mem_ctl.clr = (state == ST_IDLE) && in_valid && (mode == MODE_CLEAR);
    mem_ctl.wr  = (state == ST_EDGE);
    sctl.load   = (state == ST_LOAD);
    sctl.run    = (state == ST_RUN);
    rd_addr     = (state == ST_RUN) ? pick_idx : source_node[AW-1:0];
    out_load    = (state == ST_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Operands of the transaction in progress.
  always_ff @(posedge clk) begin
    if (accept) begin
      srow <= source_node[AW-1:0];
      tgt  <= target_node[AW-1:0];
      q_ok <= src_ok && dst_ok;
    end
  end

  // The edge write merges the target bit into the row read in the previous cycle.
  assign wr_data = rd_data | ({{(NODES - 1){1'b0}}, 1'b1} << tgt);

  gdr_adj_mem #(
    .NODES(NODES)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mem_ctl),
    .rd_addr(rd_addr),
    .wr_addr(srow),
    .wr_data(wr_data),
    .rd_data(rd_data)
  );

  gdr_search #(
    .NODES(NODES)
  ) u_search (
    .clk     (clk),
    .rst     (rst),
    .ctl     (sctl),
    .rd_data (rd_data),
    .stat    (stat),
    .pick_idx(pick_idx),
    .frontier(frontier)
  );

  // Result register; it frees up in the same cycle the receiver takes the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      path_exists <= q_ok && frontier[tgt];
    end
  end

  ap_add_writes: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_ADD && src_ok && dst_ok) |=> mem_ctl.wr)
    else $error("accepted edge was not written");

  ap_wr_alone: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.wr |-> (!mem_ctl.clr && !in_ready && !sctl.run))
    else $error("edge write overlaps other memory activity");

  ap_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && stat.quiet) |=> (state == ST_DONE))
    else $error("finished search did not report");

  ap_result_out: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == ST_IDLE))
    else $error("query result was not presented");

endmodule
